### design/ladder_lowpass_rk4_unit_defines.svh
// Assertion macros used by the ladder filter RTL.
`ifndef LADDER_LOWPASS_RK4_UNIT_DEFINES_SVH
`define LADDER_LOWPASS_RK4_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define LRK4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define LRK4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lrk4_pkg.sv
// Package with the constants and the tanh table of the ladder filter.
`default_nettype none
package lrk4_pkg;

    localparam int TANH_TABLE_BITS = 10;
    localparam int TT_SIZE         = 1 << TANH_TABLE_BITS;
    localparam int TT_SHIFT        = 27 - TANH_TABLE_BITS;
    localparam int TT_AW           = TANH_TABLE_BITS + 1;
    localparam int TT_DW           = 25;
    localparam logic [18:0] RES_MAX = 19'd360448;
    localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;

    typedef logic [TT_DW-1:0] t_tanh_tab [0:TT_SIZE];

    // Shift and subtract division of non-negative values, used while the table is built.
    function automatic longint udiv(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int bi = 62; bi >= 0; bi--) begin
            r = (r <<< 1) | ((num >>> bi) & 64'sd1);
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Builds tanh over [0, 8] in Q8.24 as (1-e)/(1+e), e formed in Q31.
    function automatic t_tanh_tab build_tanh_tab();
        longint    fac [0:TANH_TABLE_BITS];
        longint    s;
        longint    term;
        longint    sum;
        longint    e;
        longint    den;
        longint    q31;
        t_tanh_tab tab;
        q31  = 64'sd1 <<< 31;
        s    = 64'sd1 <<< (35 - TANH_TABLE_BITS);
        term = q31;
        sum  = q31;
        for (int n = 1; n <= 16; n++) begin
            term = (term * s + (64'sd1 <<< 30)) >>> 31;
            term = udiv(term + longint'(n >> 1), longint'(n));
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        fac[0] = sum;
        for (int k = 1; k <= TANH_TABLE_BITS; k++) begin
            fac[k] = (fac[k-1] * fac[k-1] + (64'sd1 <<< 30)) >>> 31;
        end
        for (int i = 0; i <= TT_SIZE; i++) begin
            e = q31;
            for (int k = 0; k <= TANH_TABLE_BITS; k++) begin
                if (((i >> k) & 1) == 1) begin
                    e = (e * fac[k] + (64'sd1 <<< 30)) >>> 31;
                end
            end
            if (e > q31) begin
                e = q31;
            end
            if (e < 0) begin
                e = 0;
            end
            den    = q31 + e;
            tab[i] = TT_DW'(udiv(((q31 - e) <<< 24) + (den >>> 1), den));
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TAB = build_tanh_tab();

endpackage
`default_nettype wire

### design/lrk4_tanh_rom.sv
// Two-port registered-read ROM holding the tanh table.
`default_nettype none
module lrk4_tanh_rom (
    input  wire logic                        i_clk,
    input  wire logic [lrk4_pkg::TT_AW-1:0] i_addr_a,
    input  wire logic [lrk4_pkg::TT_AW-1:0] i_addr_b,
    output logic      [lrk4_pkg::TT_DW-1:0] o_data_a,
    output logic      [lrk4_pkg::TT_DW-1:0] o_data_b
);

    lrk4_pkg::t_tanh_tab r_rom;
    logic [lrk4_pkg::TT_DW-1:0] r_data_a;
    logic [lrk4_pkg::TT_DW-1:0] r_data_b;

    assign r_rom = lrk4_pkg::TANH_TAB;

    // Addresses past the last entry are clamped to it.
    always_ff @(posedge i_clk) begin
        r_data_a <= (i_addr_a > lrk4_pkg::TT_AW'(lrk4_pkg::TT_SIZE))
                    ? r_rom[lrk4_pkg::TT_SIZE] : r_rom[i_addr_a];
        r_data_b <= (i_addr_b > lrk4_pkg::TT_AW'(lrk4_pkg::TT_SIZE))
                    ? r_rom[lrk4_pkg::TT_SIZE] : r_rom[i_addr_b];
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule
`default_nettype wire

### design/ladder_lowpass_rk4_unit.sv
// A new input word is taken only once the result of the last one is in the output register.
// One shared 34x33 multiplier does all the multiplications.
// The four derivative passes are followed by the final update.
// The input is not ready while a word is in flight; the output register holds a result.
// Reset (synchronous, active low) clears the four stage values and the handshake state.
`default_nettype none
`include "ladder_lowpass_rk4_unit_defines.svh"
module ladder_lowpass_rk4_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [31:0] i_sample_in,
    input  wire logic        [17:0] i_cutoff_step,
    input  wire logic        [18:0] i_feedback_gain,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed      [31:0] o_lowpass_out,
    output logic signed      [31:0] o_highpass_out
);

    // The sequencer walks through four derivative passes. Each pass forms the
    // feedback term, evaluates five tanh values by table interpolation, then
    // updates the four trial stage values (not in the fourth pass) and sums
    // weighted derivatives. The final update scales each sum by g/6 and saturates.
    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_FB   = 13'b0000000000010,
        S_FBW  = 13'b0000000000100,
        S_TRD  = 13'b0000000001000,
        S_TMUL = 13'b0000000010000,
        S_TWR  = 13'b0000000100000,
        S_UPD  = 13'b0000001000000,
        S_UWR  = 13'b0000010000000,
        S_AMUL = 13'b0000100000000,
        S_ADIV = 13'b0001000000000,
        S_AQM  = 13'b0010000000000,
        S_AWR  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    localparam int TS = lrk4_pkg::TT_SHIFT;
    localparam int AW = lrk4_pkg::TT_AW;
    localparam int DW = lrk4_pkg::TT_DW;

    t_state                  r_state, n_state;
    logic [1:0]              r_eval;
    logic [2:0]              r_j;
    logic signed [31:0]      r_st   [4];
    logic signed [33:0]      r_tmp  [4];
    logic signed [29:0]      r_acc  [4];
    logic signed [25:0]      r_t    [5];
    logic signed [31:0]      r_x;
    logic        [17:0]      r_g;
    logic        [18:0]      r_k;
    logic signed [37:0]      r_arg;
    logic        [TS-1:0]    r_frac;
    logic                    r_neg;
    logic        [31:0]      r_q;
    logic signed [66:0]      r_prod;
    logic                    r_out_valid;
    logic signed [31:0]      r_lp;
    logic signed [31:0]      r_hp;

    logic signed [33:0]      mul_a;
    logic signed [32:0]      mul_b;
    logic signed [37:0]      tanh_arg;
    logic        [37:0]      tanh_mag;
    logic                    tanh_big;
    logic        [AW-1:0]    rom_addr_a;
    logic        [AW-1:0]    rom_addr_b;
    logic        [DW-1:0]    rom_a;
    logic        [DW-1:0]    rom_b;
    logic signed [26:0]      deriv;
    logic signed [66:0]      rnd_res;
    logic        [4:0]       rnd_sh;
    logic        [66:0]      prod_mag;
    logic signed [25:0]      tanh_y;
    logic signed [31:0]      q3;
    logic                    lane_state;
    logic                    out_stall;

    // Round to nearest by a power of two, ties away from zero.
    function automatic logic signed [66:0] rnd_shift(input logic signed [66:0] v,
                                                     input logic [4:0] sh);
        logic [66:0] mag;
        logic [66:0] q;
        mag = v[66] ? 67'(-v) : 67'(v);
        q   = (mag + (67'd1 << (sh - 5'd1))) >> sh;
        return v[66] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    lrk4_tanh_rom u_rom (
        .i_clk   (i_clk),
        .i_addr_a(rom_addr_a),
        .i_addr_b(rom_addr_b),
        .o_data_a(rom_a),
        .o_data_b(rom_b)
    );

    // The tanh argument is one of the trial stage values or the feedback input.
    // Magnitudes of 8.0 and above read the last entry with a zero fraction.
    always_comb begin
        tanh_arg   = r_j[2] ? r_arg : 38'(r_tmp[r_j[1:0]]);
        tanh_mag   = tanh_arg[37] ? 38'(-tanh_arg) : 38'(tanh_arg);
        tanh_big   = (tanh_mag[37:27] != '0);
        rom_addr_a = tanh_big ? AW'(lrk4_pkg::TT_SIZE) : AW'(tanh_mag[26:TS]);
        rom_addr_b = AW'(tanh_mag[26:TS]) + AW'(1);
    end

    // Stage 0 is driven by the input tanh, the others by the stage before them.
    always_comb begin
        if (r_j[1:0] == 2'd0) begin
            deriv = 27'(r_t[4]) - 27'(r_t[0]);
        end else begin
            deriv = 27'(r_t[r_j[1:0] - 2'd1]) - 27'(r_t[r_j[1:0]]);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FB: begin
                mul_a = r_tmp[3];
                mul_b = $signed({14'd0, r_k});
            end
            S_TMUL: begin
                mul_a = 34'($signed({1'b0, rom_b}) - $signed({1'b0, rom_a}));
                mul_b = $signed(33'(r_frac));
            end
            S_UPD: begin
                mul_a = 34'(deriv);
                mul_b = $signed({15'd0, r_g});
            end
            S_AMUL: begin
                mul_a = 34'(r_acc[r_j[1:0]]);
                mul_b = $signed({15'd0, r_g});
            end
            S_AQM: begin
                mul_a = $signed({2'b00, r_q});
                mul_b = $signed({1'b0, lrk4_pkg::RECIP3});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_FBW:   rnd_sh = 5'd16;
            S_TWR:   rnd_sh = 5'(TS);
            default: rnd_sh = (r_eval == 2'd2) ? 5'd16 : 5'd17;
        endcase
        rnd_res  = rnd_shift(r_prod, rnd_sh);
        prod_mag = r_prod[66] ? 67'(-r_prod) : 67'(r_prod);
        tanh_y   = 26'($signed({1'b0, rom_a}) + rnd_res[25:0]);
        q3       = $signed({1'b0, r_prod[63:33]});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FB;
            S_FB:    n_state = S_FBW;
            S_FBW:   n_state = S_TRD;
            S_TRD:   n_state = S_TMUL;
            S_TMUL:  n_state = S_TWR;
            S_TWR:   n_state = r_j[2] ? S_UPD : S_TRD;
            S_UPD:   n_state = S_UWR;
            S_UWR: begin
                if (r_j[1:0] != 2'd3) begin
                    n_state = S_UPD;
                end else if (r_eval == 2'd3) begin
                    n_state = S_AMUL;
                end else begin
                    n_state = S_FB;
                end
            end
            S_AMUL:  n_state = S_ADIV;
            S_ADIV:  n_state = S_AQM;
            S_AQM:   n_state = S_AWR;
            S_AWR:   n_state = (r_j[1:0] == 2'd3) ? S_OUT : S_AMUL;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eval      <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_st[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // A new result may replace the one leaving in the same cycle.
            if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_eval <= '0;
                    r_j    <= '0;
                end
                S_FBW: r_j <= '0;
                S_TWR: r_j <= r_j[2] ? 3'd0 : r_j + 3'd1;
                S_UWR: begin
                    r_j <= (r_j[1:0] == 2'd3) ? 3'd0 : r_j + 3'd1;
                    if (r_j[1:0] == 2'd3 && r_eval != 2'd3) begin
                        r_eval <= r_eval + 2'd1;
                    end
                end
                S_AWR: begin
                    r_j <= (r_j[1:0] == 2'd3) ? 3'd0 : r_j + 3'd1;
                    r_st[r_j[1:0]] <= sat32(34'(r_st[r_j[1:0]])
                                            + (r_neg ? -34'(q3) : 34'(q3)));
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_x <= i_sample_in;
                r_g <= i_cutoff_step;
                r_k <= (i_feedback_gain > lrk4_pkg::RES_MAX) ? lrk4_pkg::RES_MAX
                                                              : i_feedback_gain;
                for (int i = 0; i < 4; i++) begin
                    r_tmp[i] <= 34'(r_st[i]);
                    r_acc[i] <= '0;
                end
            end
            S_FBW: r_arg <= 38'(r_x) - rnd_res[37:0];
            S_TRD: begin
                r_frac <= tanh_big ? '0 : tanh_mag[TS-1:0];
                r_neg  <= tanh_arg[37];
            end
            S_TWR: r_t[r_j] <= r_neg ? -tanh_y : tanh_y;
            S_UPD: begin
                if (r_eval == 2'd1 || r_eval == 2'd2) begin
                    r_acc[r_j[1:0]] <= r_acc[r_j[1:0]] + (30'(deriv) <<< 1);
                end else begin
                    r_acc[r_j[1:0]] <= r_acc[r_j[1:0]] + 30'(deriv);
                end
            end
            S_UWR: begin
                if (r_eval != 2'd3) begin
                    r_tmp[r_j[1:0]] <= 34'(r_st[r_j[1:0]]) + rnd_res[33:0];
                end
            end
            S_ADIV: begin
                r_q   <= 32'((prod_mag + 67'd196608) >> 17);
                r_neg <= r_prod[66];
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_lp <= r_st[3];
                    r_hp <= sat32(34'(r_x) - 34'(r_st[3]));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_lowpass_out  = r_lp;
    assign o_highpass_out = r_hp;

    // States that index one of the four stage lanes.
    assign lane_state = (r_state == S_UPD) || (r_state == S_UWR)
                        || (r_state == S_AMUL) || (r_state == S_AWR);
    assign out_stall  = (r_state == S_OUT) && r_out_valid && !i_out_ready;

    `LRK4_ASSERT_NOW(a_j_range, i_clk, i_rst_n, r_j[2], r_j[1:0] == 2'd0, "tanh index past input")
    `LRK4_ASSERT_NOW(a_lane_range, i_clk, i_rst_n, lane_state, !r_j[2], "lane index out of range")
    `LRK4_ASSERT_NOW(a_final_pass, i_clk, i_rst_n, r_state == S_AMUL, r_eval == 2'd3, "early update")
    `LRK4_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, r_state == S_OUT, "result overwritten")

endmodule
`default_nettype wire

### dv/ladder_lowpass_rk4_unit_test.sv
// Self-checking testbench for the four-stage ladder low-pass filter with RK4 update.
`timescale 1ns / 1ps
`default_nettype none
module ladder_lowpass_rk4_unit_test;

    // The tanh table is rebuilt here from its mathematical definition.
    localparam int TBITS   = 10;
    localparam int TSIZE   = 1 << TBITS;
    localparam int TSHIFT  = 27 - TBITS;
    localparam longint K_MAX = 360448;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_sample_in;
    logic        [17:0] i_cutoff_step;
    logic        [18:0] i_feedback_gain;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_lowpass_out;
    logic signed [31:0] o_highpass_out;

    ladder_lowpass_rk4_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_cutoff_step  (i_cutoff_step),
        .i_feedback_gain(i_feedback_gain),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_lowpass_out  (o_lowpass_out),
        .o_highpass_out (o_highpass_out)
    );

    typedef struct packed {
        logic signed [31:0] lowpass;
        logic signed [31:0] highpass;
    } filter_word_t;

    longint       tanh_q24 [0:TSIZE];
    longint       ladder_state [4];
    filter_word_t pending_words [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous fixed limit: 1223 words plus heavy stalls.
    initial begin
        #50ms;
        $display("ladder_lowpass_rk4_unit_test: errors");
        $finish;
    end

    function automatic longint round_div(longint v, longint d);
        if (v >= 0) begin
            return (v + d / 2) / d;
        end
        return -((-v + d / 2) / d);
    endfunction

    function automatic longint q31_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 30)) >>> 31;
    endfunction

    // Table of tanh over [0, 8] in Q8.24, built from a Q31 exponential.
    task automatic fill_tanh_table();
        longint fac [0:TBITS];
        longint step;
        longint term;
        longint sum;
        longint e;
        longint den;
        longint one;
        one  = 64'sd1 <<< 31;
        step = 64'sd1 <<< (35 - TBITS);
        term = one;
        sum  = one;
        for (int n = 1; n <= 16; n++) begin
            term = (term * step + (64'sd1 <<< 30)) >>> 31;
            term = (term + n / 2) / n;
            sum  = (n % 2 == 1) ? sum - term : sum + term;
        end
        fac[0] = sum;
        for (int k = 1; k <= TBITS; k++) begin
            fac[k] = q31_mul(fac[k-1], fac[k-1]);
        end
        for (int i = 0; i <= TSIZE; i++) begin
            e = one;
            for (int k = 0; k <= TBITS; k++) begin
                if ((i >> k) & 1) begin
                    e = q31_mul(e, fac[k]);
                end
            end
            if (e > one) begin
                e = one;
            end
            if (e < 0) begin
                e = 0;
            end
            den = one + e;
            tanh_q24[i] = (((one - e) <<< 24) + den / 2) / den;
        end
    endtask

    function automatic longint tanh_lookup(longint x);
        longint mag;
        longint idx;
        longint frac;
        longint y;
        longint a;
        longint b;
        mag = (x < 0) ? -x : x;
        if (mag >= (64'sd1 <<< 27)) begin
            y = tanh_q24[TSIZE];
        end else begin
            idx  = mag >>> TSHIFT;
            frac = mag & ((64'sd1 <<< TSHIFT) - 1);
            a    = tanh_q24[idx];
            b    = tanh_q24[idx + 1];
            y    = a + round_div((b - a) * frac, 64'sd1 <<< TSHIFT);
        end
        return (x < 0) ? -y : y;
    endfunction

    // Slopes of the four stages for a given stage vector.
    task automatic ladder_slopes(input longint s [4], input longint x, input longint k,
                                 output longint d [4]);
        longint t [4];
        for (int i = 0; i < 4; i++) begin
            t[i] = tanh_lookup(s[i]);
        end
        d[0] = tanh_lookup(x - round_div(k * s[3], 64'sd1 <<< 16)) - t[0];
        for (int i = 1; i < 4; i++) begin
            d[i] = t[i-1] - t[i];
        end
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Advances the filter by one RK4 step and queues the expected word.
    task automatic advance_ladder(input logic signed [31:0] sample, input logic [17:0] g_in,
                                  input logic [18:0] k_in);
        longint x;
        longint g;
        longint k;
        longint tmp [4];
        longint d1 [4];
        longint d2 [4];
        longint d3 [4];
        longint d4 [4];
        filter_word_t w;
        x = sample;
        g = g_in;
        k = (k_in > K_MAX) ? K_MAX : k_in;
        ladder_slopes(ladder_state, x, k, d1);
        for (int i = 0; i < 4; i++) begin
            tmp[i] = ladder_state[i] + round_div(g * d1[i], 64'sd1 <<< 17);
        end
        ladder_slopes(tmp, x, k, d2);
        for (int i = 0; i < 4; i++) begin
            tmp[i] = ladder_state[i] + round_div(g * d2[i], 64'sd1 <<< 17);
        end
        ladder_slopes(tmp, x, k, d3);
        for (int i = 0; i < 4; i++) begin
            tmp[i] = ladder_state[i] + round_div(g * d3[i], 64'sd1 <<< 16);
        end
        ladder_slopes(tmp, x, k, d4);
        for (int i = 0; i < 4; i++) begin
            ladder_state[i] = clamp32(ladder_state[i] + round_div(
                g * (d1[i] + 2 * d2[i] + 2 * d3[i] + d4[i]), 64'sd6 <<< 16));
        end
        w.lowpass  = 32'(ladder_state[3]);
        w.highpass = 32'(clamp32(x - ladder_state[3]));
        pending_words.push_back(w);
    endtask

    // Offers one word, with a random gap first, and holds it until accepted.
    // Valid drops only during a gap, so a word sent back to back keeps it high.
    task automatic send_sample(input logic signed [31:0] sample, input logic [17:0] g,
                               input logic [18:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_in     <= sample;
        i_cutoff_step   <= g;
        i_feedback_gain <= k;
        advance_ladder(sample, g, k);
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        filter_word_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word lp=%0d hp=%0d", $time,
                         o_lowpass_out, o_highpass_out);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_lowpass_out !== want.lowpass) begin
                    $display("%0t: lowpass expected %0d actual %0d", $time,
                             want.lowpass, o_lowpass_out);
                    error_count++;
                end
                if (o_highpass_out !== want.highpass) begin
                    $display("%0t: highpass expected %0d actual %0d", $time,
                             want.highpass, o_highpass_out);
                    error_count++;
                end
            end
        end
    end

    // Stops offering and waits until every expected word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Extremes of every field, both saturation cases and the resonance clamp.
    task automatic test_directed();
        send_sample(32'sh7FFFFFFF, 18'h3FFFF, 19'd0);
        send_sample(32'sh7FFFFFFF, 18'h3FFFF, 19'd0);
        send_sample(32'sh80000000, 18'h3FFFF, 19'h7FFFF);
        send_sample(32'sh80000000, 18'h3FFFF, 19'h7FFFF);
        send_sample(32'sh7FFFFFFF, 18'h3FFFF, 19'd360448);
        send_sample(32'sh7FFFFFFF, 18'h3FFFF, 19'd360449);
        send_sample(32'sh0, 18'h0, 19'd0);
        send_sample(32'sh01000000, 18'd4096, 19'd262144);
        send_sample(32'sh01000000, 18'd4096, 19'd262144);
        send_sample(-32'sh01000000, 18'd65536, 19'd360448);
        send_sample(32'sh07FFFFFF, 18'd131072, 19'd65536);
        send_sample(32'sh08000000, 18'd131072, 19'd65536);
        send_sample(-32'sh08000000, 18'd200000, 19'd100000);
        send_sample(32'sh00000001, 18'd1, 19'd1);
        send_sample(32'shFFFFFFFF, 18'h3FFFF, 19'h55555);
        send_sample(32'shAAAAAAAA, 18'h2AAAA, 19'h2AAAA);
        send_sample(32'sh55555555, 18'h15555, 19'h15555);
        drain_results();
    endtask

    // Mostly musical signals with moderate cutoffs, plus occasional full-range noise.
    task automatic test_random(input int count);
        logic signed [31:0] x;
        logic [17:0] g;
        logic [18:0] k;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 7) begin
                x = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
                g = 18'($urandom_range(0, 70000));
                k = 19'($urandom_range(0, K_MAX));
            end else begin
                x = 32'($urandom);
                g = 18'($urandom);
                k = 19'($urandom);
            end
            send_sample(x, g, k);
        end
        drain_results();
    endtask

    // The receiver stalls long enough for the block to fill and hold off its input.
    task automatic test_backpressure();
        hold_cycles <= 600;
        for (int n = 0; n < 6; n++) begin
            send_sample(32'($urandom), 18'($urandom_range(0, 70000)), 19'($urandom));
        end
        drain_results();
    endtask

    initial begin
        error_count     = 0;
        hold_cycles     = 0;
        send_idle_pct   = 31;
        recv_idle_pct   = 83;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_sample_in     = '0;
        i_cutoff_step   = '0;
        i_feedback_gain = '0;
        fill_tanh_table();
        for (int i = 0; i < 4; i++) begin
            ladder_state[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random(400);
        send_idle_pct = 83;
        recv_idle_pct = 31;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);

        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ladder_lowpass_rk4_unit_test: clean");
        end else begin
            $display("ladder_lowpass_rk4_unit_test: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
